[design/dccd_pkg.sv]
`default_nettype none

package dccd_pkg;

    // Field widths.
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned YEAR_W  = 24;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;

    // Both divisions work on a non-negative 35-bit dividend.
    localparam int unsigned REM_W = 35;

    // Quotient bits of the two divisions.
    localparam int unsigned N1 = 17;
    localparam int unsigned N2 = 24;

    // Each quotient is first estimated as (x * RECIP) >> RECIP_S with
    // RECIP = floor(2^35 / divisor). For every x below 2^35 the estimate is
    // the true quotient or one less, so one compare and subtract finishes it.
    localparam int unsigned RECIP_S = 35;

    // Century division: floor((4*jdn + 274277) / 146097).
    localparam logic [REM_W-1:0] DIV1 = 35'd146097;
    // The dividend is shifted up by K1 * 146097 so that it is never negative.
    // With jdn = code - 2^31 + 2440588 it becomes 4*code + BIAS1.
    localparam logic [REM_W-1:0] BIAS1 = 35'd378847;
    localparam logic signed [N1:0] K1 = 18'sd58730;
    localparam logic [17:0] RECIP_ERA = 18'd235184;
    // The remainder of the estimate stays below twice the divisor.
    localparam int unsigned REM1_W = 19;
    localparam logic [REM1_W-1:0] ERA_DAYS = 19'd146097;

    // Four-year cycle division: e / 1461 with e = 4*f + 3.
    localparam logic [REM_W-1:0] DIV2 = 35'd1461;
    // e + K2 * 1461 with K2 = 5900000 equals 4*code + 4*q2 + BIAS2.
    localparam logic [REM_W-1:0] BIAS2 = 35'd39733215;
    // K2 plus the 4716 year offset of the conversion.
    localparam logic signed [N2:0] YEAR_OFFS = 25'sd5904716;
    localparam logic [24:0] RECIP_CYCLE = 25'd23517959;
    localparam int unsigned REM2_W = 12;
    localparam logic [REM2_W-1:0] CYCLE_DAYS = 12'd1461;

    // floor(h / 153) is (h * 1714) >> 18 for every h below 2048.
    localparam logic [10:0] MONTH_SPAN   = 11'd153;
    localparam logic [10:0] RECIP_SPAN   = 11'd1714;
    localparam int unsigned RECIP_SPAN_S = 18;

    // floor(m / 5) is (m * 205) >> 10 for every m below 153.
    localparam logic [7:0]  RECIP_FIVE   = 8'd205;
    localparam int unsigned RECIP_FIVE_S = 10;

    // Month numbering: the conversion counts months from March.
    localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;
    localparam logic [MONTH_W-1:0] MONTHS      = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [DAY_W-1:0]   FEB_MAX_DAY = 5'd29;

    // Register stages from the input to the result registers.
    localparam int unsigned LATENCY = 12;

endpackage

`default_nettype wire

[design/day_count_to_calendar_date_top.sv]
`default_nettype none

// Day code to proleptic Gregorian date converter. Drive a 32-bit day code
// (days since 1970-01-01 plus 2^31) on i_day_code and raise start; the
// transaction is taken at the rising edge where start is high and busy is
// low. busy is high during reset and until r_run is set after it, then stays
// low for good, so one transaction can be issued in every clock cycle. The
// block is a fixed pipeline of 12 register stages: the entry register, three
// stages for the 146097-day era division (reciprocal estimate, remainder,
// correction), one for the Gregorian correction, one for the four-year cycle
// dividend, three for the 1461-day cycle division, and three for the month,
// the day and the year. The result of a transaction appears on o_year,
// o_month and o_day_of_month for exactly one cycle with o_strobe high, once
// it has passed through all of these stages, and results leave in the
// order the codes came in. The receiver cannot stall the block, so it must
// capture the result in that cycle. Every code gives a valid date; the year
// is signed two's complement, with 0 meaning 1 BC.
module day_count_to_calendar_date_top
    import dccd_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire  [CODE_W-1:0]        i_day_code,
    output logic                     o_strobe,
    output logic signed [YEAR_W-1:0] o_year,
    output logic [MONTH_W-1:0]       o_month,
    output logic [DAY_W-1:0]         o_day_of_month
);

    // Valid bit positions of the stages that the assertions look at.
    localparam int unsigned V_ERA_REM   = 2;
    localparam int unsigned V_CYCLE_MOD = 8;

    logic r_run;
    logic accept;

    // One valid bit per stage; position 0 is the entry register and the
    // last position marks the result registers.
    logic [LATENCY-1:0] r_v;

    assign busy   = ~r_run;
    assign accept = start & r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_v   <= '0;
        end else begin
            r_run <= 1'b1;
            r_v   <= {r_v[LATENCY-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // Era division. The entry register holds the biased dividend. The
    // quotient is estimated by a reciprocal multiplication, the remainder
    // of the estimate is formed, and one compare raises the estimate when
    // the remainder still holds a whole divisor.
    // ------------------------------------------------------------------
    logic [REM_W-1:0]  r_a_x;
    logic [CODE_W-1:0] r_a_code;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_x    <= {1'b0, i_day_code, 2'b00} + BIAS1;
            r_a_code <= i_day_code;
        end
    end

    logic [REM_W+17:0]  a_prod;
    logic [REM_W-1:0]   a_qd;
    logic [REM_W-1:0]   a_diff;
    logic               a_fits;
    logic [N1-1:0]      r_a_qe;
    logic [REM_W-1:0]   r_a_x1;
    logic [REM1_W-1:0]  r_a_rem;
    logic [N1-1:0]      r_a_qe1;
    logic [N1-1:0]      r_a_q;
    logic [CODE_W-1:0]  r_a_code1;
    logic [CODE_W-1:0]  r_a_code2;
    logic [CODE_W-1:0]  r_a_code3;

    assign a_prod = {{18{1'b0}}, r_a_x} * {{REM_W{1'b0}}, RECIP_ERA};
    assign a_qd   = {{(REM_W-N1){1'b0}}, r_a_qe} * DIV1;
    assign a_diff = r_a_x1 - a_qd;
    assign a_fits = (r_a_rem >= ERA_DAYS);

    always_ff @(posedge i_clk) begin
        r_a_qe    <= a_prod[RECIP_S+N1-1:RECIP_S];
        r_a_x1    <= r_a_x;
        r_a_code1 <= r_a_code;
        r_a_rem   <= a_diff[REM1_W-1:0];
        r_a_qe1   <= r_a_qe;
        r_a_code2 <= r_a_code1;
        r_a_q     <= r_a_qe1 + {{(N1-1){1'b0}}, a_fits};
        r_a_code3 <= r_a_code2;
    end

    // ------------------------------------------------------------------
    // Gregorian correction: q2 = floor(3 * q1 / 4), then the dividend of
    // the four-year cycle division in its biased, non-negative form.
    // ------------------------------------------------------------------
    logic signed [N1:0]   q1;
    logic signed [N1+2:0] q1_ext;
    logic signed [N1+2:0] q1_x3;
    logic signed [N1:0]   n_f_q2;
    logic signed [N1:0]   r_f_q2;
    logic [CODE_W-1:0]    r_f_code;

    assign q1     = $signed({1'b0, r_a_q}) - K1;
    assign q1_ext = {{2{q1[N1]}}, q1};
    assign q1_x3  = (q1_ext <<< 1) + q1_ext;
    // Dropping the two low bits of a two's complement value floors it.
    assign n_f_q2 = q1_x3[N1+2:2];

    always_ff @(posedge i_clk) begin
        r_f_q2   <= n_f_q2;
        r_f_code <= r_a_code3;
    end

    logic [REM_W-1:0] r_b_x;

    always_ff @(posedge i_clk) begin
        r_b_x <= {1'b0, r_f_code, 2'b00}
               + {{(REM_W-N1-3){r_f_q2[N1]}}, r_f_q2, 2'b00}
               + BIAS2;
    end

    // ------------------------------------------------------------------
    // Four-year cycle division, built like the era division. The final
    // remainder is floor_mod(e, 1461).
    // ------------------------------------------------------------------
    logic [REM_W+24:0]  b_prod;
    logic [REM_W-1:0]   b_qd;
    logic [REM_W-1:0]   b_diff;
    logic               b_fits;
    logic [REM2_W-1:0]  n_b_mod;
    logic [N2-1:0]      r_b_qe;
    logic [REM_W-1:0]   r_b_x1;
    logic [REM2_W-1:0]  r_b_rem;
    logic [N2-1:0]      r_b_qe1;
    logic [REM2_W-1:0]  r_b_mod;
    logic [N2-1:0]      r_b_q;

    assign b_prod  = {{25{1'b0}}, r_b_x} * {{REM_W{1'b0}}, RECIP_CYCLE};
    assign b_qd    = {{(REM_W-N2){1'b0}}, r_b_qe} * DIV2;
    assign b_diff  = r_b_x1 - b_qd;
    assign b_fits  = (r_b_rem >= CYCLE_DAYS);
    assign n_b_mod = b_fits ? (r_b_rem - CYCLE_DAYS) : r_b_rem;

    always_ff @(posedge i_clk) begin
        r_b_qe  <= b_prod[RECIP_S+N2-1:RECIP_S];
        r_b_x1  <= r_b_x;
        r_b_rem <= b_diff[REM2_W-1:0];
        r_b_qe1 <= r_b_qe;
        r_b_mod <= n_b_mod;
        r_b_q   <= r_b_qe1 + {{(N2-1){1'b0}}, b_fits};
    end

    // ------------------------------------------------------------------
    // Day of the year from March (g), h = 5g + 2 and the month index.
    // ------------------------------------------------------------------
    logic [8:0]         g_day;
    logic [10:0]        n_g_h;
    logic [21:0]        span_prod;
    logic signed [N2:0] year_full;
    logic [10:0]        r_g_h;
    logic [3:0]         r_g_hq;
    logic [YEAR_W-1:0]  r_g_yb;

    assign g_day     = r_b_mod[10:2];
    assign n_g_h     = {g_day, 2'b00} + {2'b00, g_day} + 11'd2;
    assign span_prod = 22'(n_g_h) * 22'(RECIP_SPAN);
    assign year_full = $signed({1'b0, r_b_q}) - YEAR_OFFS;

    always_ff @(posedge i_clk) begin
        r_g_h  <= n_g_h;
        r_g_hq <= span_prod[RECIP_SPAN_S+3:RECIP_SPAN_S];
        r_g_yb <= year_full[YEAR_W-1:0];
    end

    // ------------------------------------------------------------------
    // Remainder within the month and the calendar month number.
    // ------------------------------------------------------------------
    logic [10:0]        month_start;
    logic [10:0]        h_rem;
    logic [MONTH_W-1:0] month_raw;
    logic               n_h_jan;
    logic [7:0]         r_h_hm;
    logic [MONTH_W-1:0] r_h_mm;
    logic               r_h_jan;
    logic [YEAR_W-1:0]  r_h_yb;

    assign month_start = 11'({7'd0, r_g_hq} * MONTH_SPAN);
    assign h_rem       = r_g_h - month_start;
    assign month_raw   = r_g_hq + MONTH_MARCH;
    assign n_h_jan     = (month_raw > MONTHS);

    always_ff @(posedge i_clk) begin
        r_h_hm  <= h_rem[7:0];
        r_h_mm  <= n_h_jan ? (month_raw - MONTHS) : month_raw;
        r_h_jan <= n_h_jan;
        r_h_yb  <= r_g_yb;
    end

    // ------------------------------------------------------------------
    // Day of the month and the year, which moves up by one for January
    // and February because the conversion's year starts in March.
    // ------------------------------------------------------------------
    logic [14:0]              day_prod;
    logic [DAY_W-1:0]         r_o_day;
    logic [MONTH_W-1:0]       r_o_month;
    logic signed [YEAR_W-1:0] r_o_year;

    assign day_prod = {7'd0, r_h_hm} * {7'd0, RECIP_FIVE};

    always_ff @(posedge i_clk) begin
        r_o_day   <= day_prod[RECIP_FIVE_S+4:RECIP_FIVE_S] + 5'd1;
        r_o_month <= r_h_mm;
        r_o_year  <= $signed(r_h_yb + YEAR_W'(r_h_jan));
    end

    assign o_strobe       = r_v[LATENCY-1];
    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day_of_month = r_o_day;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without a transaction accepted LATENCY cycles before");

    a_div1_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[V_ERA_REM] |-> ({1'b0, r_a_rem} < {ERA_DAYS, 1'b0}))
        else $error("era quotient estimate more than one below the quotient");

    a_div2_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[V_CYCLE_MOD] |-> (r_b_mod < CYCLE_DAYS))
        else $error("four-year cycle division left a remainder out of range");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_month >= MONTH_JAN && o_month <= MONTHS && o_day_of_month != '0))
        else $error("month or day of month out of range");

    a_february: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_month == MONTH_FEB) |-> (o_day_of_month <= FEB_MAX_DAY))
        else $error("February date beyond its last day");

endmodule

`default_nettype wire
